>>> src/bts_pkg.sv
`timescale 1ns / 1ps
package bts_pkg;
	localparam int TRIANGLES = 256;
	localparam int TEXELS = 65536;
	localparam int MAX_DIM = 256;

	localparam logic [1:0] CMD_TEXEL = 2'd0;
	localparam logic [1:0] CMD_POS = 2'd1;
	localparam logic [1:0] CMD_UV = 2'd2;
	localparam logic [1:0] CMD_SAMPLE = 2'd3;
	localparam logic [0:0] REG_WIDTH = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;
	localparam int WBITS = 24;
	localparam logic [23:0] WMAX = 24'hFFFFFF;
	localparam int ROOT_STEPS = 51;
	localparam int DIV_STEPS = 24;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] tri_index;
		logic [1:0] corner;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [23:0] pz;
		logic [15:0] texel_addr;
		logic [7:0] texel_red;
		logic [7:0] texel_green;
		logic [7:0] texel_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] column;
		logic [7:0] row;
		logic degenerate;
	} out_item_t;
endpackage

>>> src/bts_stream_if.sv
`timescale 1ns / 1ps
interface bts_stream_if #(parameter int W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> src/bts_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module bts_isqrt #(parameter int N = 102, parameter int TW = 8) (
	input logic clk,
	input logic en,
	input logic [N-1:0] rad,
	input logic [TW-1:0] tag_in,
	output logic [N/2-1:0] root,
	output logic [TW-1:0] tag_out
);
	localparam int S = N / 2;
	logic [N-1:0] rem_s [0:S];
	logic [S-1:0] q_s [0:S];
	logic [TW-1:0] t_s [0:S];
	assign rem_s[0] = rad;
	assign q_s[0] = '0;
	assign t_s[0] = tag_in;
	for (genvar i = 0; i < S; i++) begin : g_st
		localparam int B = S - 1 - i;
		logic [N+1:0] trial;
		logic [N+1:0] rr;
		always_comb begin
			trial = ({{(N-S+2){1'b0}}, q_s[i]} << (B + 1)) | ((N+2)'(1) << (2 * B));
			rr = {2'b00, rem_s[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				t_s[i+1] <= t_s[i];
				if (rr >= trial) begin
					rem_s[i+1] <= N'(rr - trial);
					q_s[i+1] <= q_s[i] | (S'(1) << B);
				end else begin
					rem_s[i+1] <= rem_s[i];
					q_s[i+1] <= q_s[i];
				end
			end
		end
	end
	assign root = q_s[S];
	assign tag_out = t_s[S];
endmodule

>>> src/bts_sampler_core.sv
`timescale 1ns / 1ps
// Sample pipeline: memory read, cross products, roots, divides, interpolation, texel read.
module bts_sampler_core (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input bts_pkg::in_item_t in_item,
	input logic [8:0] tex_width,
	input logic [8:0] tex_height,
	output logic out_valid,
	output bts_pkg::out_item_t out_item,
	output logic busy
);
	import bts_pkg::*;
	localparam int TB = TRIANGLES > 1 ? $clog2(TRIANGLES) : 1;
	localparam int XB = TEXELS > 1 ? $clog2(TEXELS) : 1;
	localparam int DB = $clog2(MAX_DIM + 1);
	localparam int DEPTH = 13 + ROOT_STEPS + DIV_STEPS;

	// storage, one memory per corner so that a sample reads all three in the same cycle
	logic [71:0] vmem0 [0:TRIANGLES-1];
	logic [71:0] vmem1 [0:TRIANGLES-1];
	logic [71:0] vmem2 [0:TRIANGLES-1];
	logic [47:0] tmem0 [0:TRIANGLES-1];
	logic [47:0] tmem1 [0:TRIANGLES-1];
	logic [47:0] tmem2 [0:TRIANGLES-1];
	logic [23:0] xmem [0:TEXELS-1];

	logic acc;
	logic [TB-1:0] ti;
	logic tri_ok;
	assign acc = en && in_valid;
	assign ti = TB'(in_item.tri_index);
	assign tri_ok = {24'd0, in_item.tri_index} < 32'(TRIANGLES);

	always_ff @(posedge clk) begin
		if (acc && in_item.cmd == CMD_TEXEL && 32'(in_item.texel_addr) < 32'(TEXELS))
			xmem[XB'(in_item.texel_addr)] <= {in_item.texel_red, in_item.texel_green,
				in_item.texel_blue};
		if (acc && in_item.cmd == CMD_POS && tri_ok) begin
			if (in_item.corner == 2'd0) vmem0[ti] <= {in_item.px, in_item.py, in_item.pz};
			if (in_item.corner == 2'd1) vmem1[ti] <= {in_item.px, in_item.py, in_item.pz};
			if (in_item.corner == 2'd2) vmem2[ti] <= {in_item.px, in_item.py, in_item.pz};
		end
		if (acc && in_item.cmd == CMD_UV && tri_ok) begin
			if (in_item.corner == 2'd0) tmem0[ti] <= {in_item.px, in_item.py};
			if (in_item.corner == 2'd1) tmem1[ti] <= {in_item.px, in_item.py};
			if (in_item.corner == 2'd2) tmem2[ti] <= {in_item.px, in_item.py};
		end
	end

	// stage 1: triangle read. Loads before a sample are ordered by the pipeline:
	// a load is seen by any read at a later clock edge than its write.
	logic [71:0] v0_s1, v1_s1, v2_s1;
	logic [47:0] t0_s1, t1_s1, t2_s1;
	logic [71:0] h_s1;
	logic vld_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			v0_s1 <= vmem0[ti];
			v1_s1 <= vmem1[ti];
			v2_s1 <= vmem2[ti];
			t0_s1 <= tmem0[ti];
			t1_s1 <= tmem1[ti];
			t2_s1 <= tmem2[ti];
			h_s1 <= {in_item.px, in_item.py, in_item.pz};
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc && in_item.cmd == CMD_SAMPLE;
		end
	end

	function automatic logic signed [25:0] cmp(input logic [71:0] p, input int k);
		return 26'(signed'(p[71-24*k -: 24]));
	endfunction

	// stage 2: differences (26 bit signed)
	logic signed [25:0] ab_s2 [3], ac_s2 [3], d0_s2 [3], d1_s2 [3], d2_s2 [3];
	logic [143:0] tc_s2;
	logic vld_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ab_s2[k] <= cmp(v1_s1, k) - cmp(v0_s1, k);
				ac_s2[k] <= cmp(v2_s1, k) - cmp(v0_s1, k);
				d0_s2[k] <= cmp(v0_s1, k) - cmp(h_s1, k);
				d1_s2[k] <= cmp(v1_s1, k) - cmp(h_s1, k);
				d2_s2[k] <= cmp(v2_s1, k) - cmp(h_s1, k);
			end
			tc_s2 <= {t0_s1, t1_s1, t2_s1};
		end
	end

	// stage 3: products, stage 4: cross components and magnitudes
	logic signed [51:0] pa_s3 [6], p1_s3 [6], p2_s3 [6];
	logic [143:0] tc_s3, tc_s4;
	logic [50:0] ma_s4 [3], m1_s4 [3], m2_s4 [3];
	function automatic void xprod(input logic signed [25:0] a [3], input logic signed [25:0] b [3],
		output logic signed [51:0] p [6]);
		p[0] = a[1] * b[2]; p[1] = a[2] * b[1];
		p[2] = a[2] * b[0]; p[3] = a[0] * b[2];
		p[4] = a[0] * b[1]; p[5] = a[1] * b[0];
	endfunction
	function automatic logic [50:0] absd(input logic signed [51:0] x, input logic signed [51:0] y);
		logic signed [52:0] d;
		d = 53'(x) - 53'(y);
		return d[52] ? 51'(-d) : 51'(d);
	endfunction
	always_ff @(posedge clk) begin
		logic signed [51:0] qa [6], q1 [6], q2 [6];
		if (en) begin
			xprod(ab_s2, ac_s2, qa);
			xprod(d1_s2, d2_s2, q1);
			xprod(d0_s2, d2_s2, q2);
			pa_s3 <= qa;
			p1_s3 <= q1;
			p2_s3 <= q2;
			tc_s3 <= tc_s2;
			for (int k = 0; k < 3; k++) begin
				ma_s4[k] <= absd(pa_s3[2*k], pa_s3[2*k+1]);
				m1_s4[k] <= absd(p1_s3[2*k], p1_s3[2*k+1]);
				m2_s4[k] <= absd(p2_s3[2*k], p2_s3[2*k+1]);
			end
			tc_s4 <= tc_s3;
		end
	end

	// stages 5..7: squares cut into 26x26 partial products, then summed
	logic [101:0] sa_s7, s1_s7, s2_s7;
	logic [143:0] tc_s5, tc_s6, tc_s7;
	logic [51:0] ll_s5 [9], lh_s5 [9], hh_s5 [9];
	logic [101:0] sq_s6 [9];
	logic [50:0] mv [9];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mv[k] = ma_s4[k];
			mv[3+k] = m1_s4[k];
			mv[6+k] = m2_s4[k];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				ll_s5[k] <= 52'(mv[k][25:0]) * 52'(mv[k][25:0]);
				lh_s5[k] <= 52'(mv[k][25:0]) * 52'(mv[k][50:26]);
				hh_s5[k] <= 52'(mv[k][50:26]) * 52'(mv[k][50:26]);
				sq_s6[k] <= 102'(ll_s5[k]) + (102'(lh_s5[k]) << 27) + (102'(hh_s5[k]) << 52);
			end
			sa_s7 <= sq_s6[0] + sq_s6[1] + sq_s6[2];
			s1_s7 <= sq_s6[3] + sq_s6[4] + sq_s6[5];
			s2_s7 <= sq_s6[6] + sq_s6[7] + sq_s6[8];
			tc_s5 <= tc_s4;
			tc_s6 <= tc_s5;
			tc_s7 <= tc_s6;
		end
	end

	// roots, three in parallel
	logic [50:0] ra, r1, r2;
	logic [143:0] tc_r;
	bts_isqrt #(.N(102), .TW(144)) u_sqa (.clk(clk), .en(en), .rad(sa_s7), .tag_in(tc_s7),
		.root(ra), .tag_out(tc_r));
	bts_isqrt #(.N(102), .TW(1)) u_sq1 (.clk(clk), .en(en), .rad(s1_s7), .tag_in(1'b0),
		.root(r1), .tag_out());
	bts_isqrt #(.N(102), .TW(1)) u_sq2 (.clk(clk), .en(en), .rad(s2_s7), .tag_in(1'b0),
		.root(r2), .tag_out());

	// divide setup: saturate when len >= area<<8, else restoring divide with 24 quotient bits
	// computing floor(len*65536/area) = quotient of len<<16, known < 2^24.
	localparam int DS = DIV_STEPS;
	logic [50:0] ar_d [0:DS];
	logic [74:0] r1_d [0:DS], r2_d [0:DS];
	logic [23:0] q1_d [0:DS], q2_d [0:DS];
	logic sat1_d [0:DS], sat2_d [0:DS];
	logic [143:0] tc_d [0:DS];
	always_ff @(posedge clk) begin
		if (en) begin
			ar_d[0] <= ra;
			r1_d[0] <= {8'd0, r1, 16'd0};
			r2_d[0] <= {8'd0, r2, 16'd0};
			q1_d[0] <= '0;
			q2_d[0] <= '0;
			sat1_d[0] <= 59'(r1) >= (59'(ra) << 8);
			sat2_d[0] <= 59'(r2) >= (59'(ra) << 8);
			tc_d[0] <= tc_r;
		end
	end
	// the remainder keeps the full dividend width, so each trial subtract is exact
	for (genvar i = 0; i < DS; i++) begin : g_div
		localparam int B = DS - 1 - i;
		logic [74:0] dv;
		assign dv = 75'(ar_d[i]) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				ar_d[i+1] <= ar_d[i];
				sat1_d[i+1] <= sat1_d[i];
				sat2_d[i+1] <= sat2_d[i];
				tc_d[i+1] <= tc_d[i];
				if (r1_d[i] >= dv && !sat1_d[i]) begin
					r1_d[i+1] <= r1_d[i] - dv;
					q1_d[i+1] <= q1_d[i] | (24'(1) << B);
				end else begin
					r1_d[i+1] <= r1_d[i];
					q1_d[i+1] <= q1_d[i];
				end
				if (r2_d[i] >= dv && !sat2_d[i]) begin
					r2_d[i+1] <= r2_d[i] - dv;
					q2_d[i+1] <= q2_d[i] | (24'(1) << B);
				end else begin
					r2_d[i+1] <= r2_d[i];
					q2_d[i+1] <= q2_d[i];
				end
			end
		end
	end

	// weights and interpolation
	logic signed [25:0] w1_e, w2_e, w3_e;
	logic degen_e;
	logic [143:0] tc_e;
	always_ff @(posedge clk) begin
		logic [23:0] a, b;
		if (en) begin
			a = sat1_d[DS] ? WMAX : q1_d[DS];
			b = sat2_d[DS] ? WMAX : q2_d[DS];
			w1_e <= 26'(a);
			w2_e <= 26'(b);
			w3_e <= 26'sd65536 - 26'(a) - 26'(b);
			degen_e <= ar_d[DS] == '0;
			tc_e <= tc_d[DS];
		end
	end
	logic signed [49:0] pu_f [3], pv_f [3];
	logic degen_f, degen_g;
	logic [31:0] fu_g, fv_g;
	always_ff @(posedge clk) begin
		if (en) begin
			pu_f[0] <= w1_e * 50'(signed'(tc_e[143:120]));
			pv_f[0] <= w1_e * 50'(signed'(tc_e[119:96]));
			pu_f[1] <= w2_e * 50'(signed'(tc_e[95:72]));
			pv_f[1] <= w2_e * 50'(signed'(tc_e[71:48]));
			pu_f[2] <= w3_e * 50'(signed'(tc_e[47:24]));
			pv_f[2] <= w3_e * 50'(signed'(tc_e[23:0]));
			degen_f <= degen_e;
			fu_g <= 32'(pu_f[0] + pu_f[1] + pu_f[2]);
			fv_g <= 32'(pv_f[0] + pv_f[1] + pv_f[2]);
			degen_g <= degen_f;
		end
	end

	// column/row pick
	logic [DB-1:0] ew, eh;
	function automatic logic [DB-1:0] effd(input logic [8:0] d);
		if (d == 9'd0) return DB'(1);
		if (32'(d) > 32'(MAX_DIM)) return DB'(MAX_DIM);
		return DB'(d);
	endfunction
	assign ew = effd(tex_width);
	assign eh = effd(tex_height);
	logic [DB-1:0] col_h, row_h;
	logic degen_h;
	always_ff @(posedge clk) begin
		logic [DB+31:0] pc, pr;
		logic [DB-1:0] c, r;
		if (en) begin
			pc = (DB+32)'(fu_g) * (DB+32)'(ew);
			pr = (DB+32)'(fv_g) * (DB+32)'(eh);
			c = pc[DB+31:32];
			r = pr[DB+31:32];
			col_h <= (c > ew - DB'(1)) ? ew - DB'(1) : c;
			row_h <= (r > eh - DB'(1)) ? eh - DB'(1) : r;
			degen_h <= degen_g;
		end
	end
	logic [XB-1:0] xa_i;
	logic [DB-1:0] col_i, row_i;
	logic degen_i;
	always_ff @(posedge clk) begin
		logic [2*DB-1:0] lin;
		if (en) begin
			lin = (2*DB)'(row_h) * (2*DB)'(ew) + (2*DB)'(col_h);
			xa_i <= XB'(lin);
			col_i <= col_h;
			row_i <= row_h;
			degen_i <= degen_h;
		end
	end
	logic [23:0] rgb_j;
	logic [7:0] col_j, row_j;
	logic degen_j;
	always_ff @(posedge clk) begin
		if (en) begin
			rgb_j <= xmem[xa_i];
			col_j <= 8'(col_i);
			row_j <= 8'(row_i);
			degen_j <= degen_i;
		end
	end
	always_comb begin
		out_item.degenerate = degen_j;
		out_item.red = degen_j ? 8'd0 : rgb_j[23:16];
		out_item.green = degen_j ? 8'd0 : rgb_j[15:8];
		out_item.blue = degen_j ? 8'd0 : rgb_j[7:0];
		out_item.column = degen_j ? 8'd0 : col_j;
		out_item.row = degen_j ? 8'd0 : row_j;
	end

	// valid shift line across the whole pipeline
	logic [DEPTH-1:0] vline_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vline_q <= '0;
		end else if (en) begin
			vline_q <= {vline_q[DEPTH-2:0], vld_s1};
		end
	end
	assign out_valid = vline_q[DEPTH-1];
	// any sample still to read the texel memory or to leave
	assign busy = vld_s1 || (|vline_q);
endmodule

>>> src/barycentric_texture_sampler.sv
`timescale 1ns / 1ps
// Barycentric texture sampler, nearest texel with clamped coordinates.
// in_ch carries commands: texel load, corner position load, corner texcoord
// load and sample. Loads give no result; each sample gives one item on out_ch.
// tex_width and tex_height are written over the APB port at 0x0 and 0x4.
// The datapath is one long pipeline advancing whenever its last stage is
// empty or being taken: roots (51 stages) and divides (24 stages) dominate.
// One item is accepted every cycle while the receiver does not stall and no
// texel load waits. Loads write the triangle and texel memories as they are
// accepted, so a sample accepted the cycle after a load sees it.
// Samples read the texel memory at the end of the pipeline, so hold a texel
// load while any sample is in flight: it is taken only once the last sample's
// result has left the pipeline, later when the receiver stalls.
// A stalled receiver freezes the whole pipeline and in_ch ready drops; the
// result register holds until taken.
// Reset clears the pipeline valid bits and sets both sizes to 256; the
// memories are not cleared and must be loaded before use.
module barycentric_texture_sampler (
	input logic clk,
	input logic arst_n,
	bts_stream_if.sink in_ch,
	bts_stream_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:2] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import bts_pkg::*;
	logic [8:0] width_q, height_q;
	logic en, ov;
	logic busy, tex_wait;
	in_item_t ii;
	out_item_t oi;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_WIDTH: width_q <= pwdata[8:0];
				REG_HEIGHT: height_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end
	assign prdata = {23'd0, paddr[2] == REG_WIDTH ? width_q : height_q};
	assign ii = in_item_t'(in_ch.data);
	assign en = !out_ch.valid || out_ch.ready;
	assign tex_wait = busy && ii.cmd == CMD_TEXEL;
	assign in_ch.ready = en && !tex_wait;
	bts_sampler_core u_core (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_ch.valid && !tex_wait),
		.in_item(ii), .tex_width(width_q), .tex_height(height_q),
		.out_valid(ov), .out_item(oi), .busy(busy));
	assign out_ch.valid = ov;
	assign out_ch.data = oi;
endmodule

>>> src/bts_checker.sv
`timescale 1ns / 1ps
module bts_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [1:0] in_cmd,
	input logic out_valid,
	input logic out_ready,
	input logic [40:0] out_data
);
	import bts_pkg::*;
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("input taken during stall");
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data[0] |-> out_data[40:1] == 40'd0) else $error("degenerate not black");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && in_valid && in_cmd != CMD_TEXEL |-> in_ready)
		else $error("idle block refuses input");
endmodule

bind barycentric_texture_sampler bts_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.data[123:122]),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
